>>> rtl/atclc_pkg.sv
`default_nettype none

package atclc_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_TERMINATOR = 2'd0;
   localparam logic [1:0] CSR_LINEFEED   = 2'd1;
   localparam logic [1:0] CSR_BACKSPACE  = 2'd2;
   localparam logic [1:0] CSR_ECHO       = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_ECHO  = 2'd0;
   localparam logic [1:0] KIND_CHAR  = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;

   localparam logic [7:0] CHAR_MASK  = 8'h7f;
   localparam logic [6:0] CH_UPPER_A = 7'h41;
   localparam logic [6:0] CH_LOWER_A = 7'h61;
   localparam logic [6:0] CH_UPPER_T = 7'h54;
   localparam logic [6:0] CH_LOWER_T = 7'h74;
   localparam logic [6:0] CH_SLASH   = 7'h2f;

   localparam logic [7:0] RESET_TERMINATOR = 8'd13;
   localparam logic [7:0] RESET_LINEFEED   = 8'd10;
   localparam logic [7:0] RESET_BACKSPACE  = 8'd8;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_LINE,
      ACT_EMPTY
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ECHO,
      ST_READ,
      ST_CHAR,
      ST_EMPTY
   } state_type;

   typedef struct packed {
      logic accept;
      logic load_echo;
      logic issue_read;
      logic load_char;
      logic load_empty;
   } cmd_type;

   typedef struct packed {
      logic       echo;
      action_type act_now;
      action_type act;
      logic       slot_free;
      logic       final_char;
   } status_type;

endpackage

`default_nettype wire

>>> rtl/atclc_ram.sv
`default_nettype none

module atclc_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/atclc_datapath.sv
`default_nettype none

module atclc_datapath
   import atclc_pkg::*;
#(
   parameter int LINE_SIZE = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_we,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata,
   input  wire logic [7:0] req_byte_in,
   input  wire logic       rsp_ready,
   input  wire cmd_type    cmd,
   output status_type      status,
   output logic            rsp_valid,
   output logic [1:0]      rsp_kind,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_last
);

   localparam int IW = $clog2(LINE_SIZE);
   localparam int AW = IW + 1;
   localparam logic [IW:0] LINE_LIMIT = (IW + 1)'(LINE_SIZE);

   logic [7:0]    term_ff, term_in;
   logic [7:0]    lf_ff, lf_in;
   logic [7:0]    bs_ff, bs_in;
   logic          echo_ff, echo_in;
   logic          seen_a_ff, seen_a_in;
   logic          in_cmd_ff, in_cmd_in;
   logic [IW-1:0] len_ff, len_in;
   logic [IW-1:0] prev_len_ff, prev_len_in;
   logic          bank_ff, bank_in;
   action_type    act_ff, act_in;
   logic          fbank_ff, fbank_in;
   logic [IW-1:0] flen_ff, flen_in;
   logic [IW-1:0] fidx_ff, fidx_in;
   logic [7:0]    byte_ff, byte_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_kind_ff, rsp_kind_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [7:0]    bare;
   logic [6:0]    ch;
   logic          is_a, is_t, is_slash, is_bs, is_term, is_lf, room;
   action_type    act_now;
   logic          wr_en;
   logic [6:0]    rd_data;
   logic          final_char;

   assign bare     = req_byte_in & CHAR_MASK;
   assign ch       = bare[6:0];
   assign is_a     = (ch == CH_UPPER_A) || (ch == CH_LOWER_A);
   assign is_t     = (ch == CH_UPPER_T) || (ch == CH_LOWER_T);
   assign is_slash = (ch == CH_SLASH);
   // registers above 127 never match the stripped character
   assign is_bs    = (bare == bs_ff);
   assign is_term  = (bare == term_ff);
   assign is_lf    = (bare == lf_ff);
   assign room     = ({1'b0, len_ff} + (IW + 1)'(1)) < LINE_LIMIT;

   assign final_char = (fidx_ff == (flen_ff - IW'(1)));

   always_comb begin
      term_in = term_ff;
      lf_in   = lf_ff;
      bs_in   = bs_ff;
      echo_in = echo_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TERMINATOR: term_in = csr_wdata;
            CSR_LINEFEED:   lf_in   = csr_wdata;
            CSR_BACKSPACE:  bs_in   = csr_wdata;
            CSR_ECHO:       echo_in = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      seen_a_in   = seen_a_ff;
      in_cmd_in   = in_cmd_ff;
      len_in      = len_ff;
      prev_len_in = prev_len_ff;
      bank_in     = bank_ff;
      act_in      = act_ff;
      fbank_in    = fbank_ff;
      flen_in     = flen_ff;
      fidx_in     = fidx_ff;
      byte_in     = byte_ff;
      act_now     = ACT_NONE;
      wr_en       = 1'b0;
      if (cmd.accept) begin
         byte_in = req_byte_in;
         fidx_in = '0;
         if (!in_cmd_ff) begin
            if (!seen_a_ff) begin
               if (is_a) begin
                  seen_a_in = 1'b1;
               end
            end else if (is_t) begin
               in_cmd_in = 1'b1;
               len_in    = '0;
            end else if (is_slash) begin
               // replay straight out of the saved bank; it stays saved
               act_now   = (prev_len_ff == '0) ? ACT_EMPTY : ACT_LINE;
               fbank_in  = ~bank_ff;
               flen_in   = prev_len_ff;
               len_in    = '0;
               seen_a_in = 1'b0;
            end else if (!is_a) begin
               seen_a_in = 1'b0;
            end
         end else if (is_bs) begin
            if (len_ff != '0) begin
               len_in = len_ff - IW'(1);
            end
         end else if (is_term) begin
            // the captured bank becomes the saved one; capture moves to the other
            act_now     = (len_ff == '0) ? ACT_EMPTY : ACT_LINE;
            fbank_in    = bank_ff;
            flen_in     = len_ff;
            prev_len_in = len_ff;
            bank_in     = ~bank_ff;
            len_in      = '0;
            seen_a_in   = 1'b0;
            in_cmd_in   = 1'b0;
         end else if (!is_lf && room) begin
            wr_en  = 1'b1;
            len_in = len_ff + IW'(1);
         end
         act_in = act_now;
      end
      if (cmd.load_char) begin
         fidx_in = fidx_ff + IW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.load_echo) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_ECHO;
         rsp_byte_in  = byte_ff;
         rsp_last_in  = (act_ff == ACT_NONE);
      end else if (cmd.load_char) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_CHAR;
         rsp_byte_in  = {1'b0, rd_data};
         rsp_last_in  = final_char;
      end else if (cmd.load_empty) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_EMPTY;
         rsp_byte_in  = '0;
         rsp_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_ff      <= RESET_TERMINATOR;
         lf_ff        <= RESET_LINEFEED;
         bs_ff        <= RESET_BACKSPACE;
         echo_ff      <= 1'b1;
         seen_a_ff    <= 1'b0;
         in_cmd_ff    <= 1'b0;
         len_ff       <= '0;
         prev_len_ff  <= '0;
         bank_ff      <= 1'b0;
         act_ff       <= ACT_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         term_ff      <= term_in;
         lf_ff        <= lf_in;
         bs_ff        <= bs_in;
         echo_ff      <= echo_in;
         seen_a_ff    <= seen_a_in;
         in_cmd_ff    <= in_cmd_in;
         len_ff       <= len_in;
         prev_len_ff  <= prev_len_in;
         bank_ff      <= bank_in;
         act_ff       <= act_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fbank_ff    <= fbank_in;
      flen_ff     <= flen_in;
      fidx_ff     <= fidx_in;
      byte_ff     <= byte_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   atclc_ram #(
      .WIDTH (7),
      .DEPTH (2 ** AW)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr ({bank_ff, len_ff}),
      .wr_data (ch),
      .rd_en   (cmd.issue_read),
      .rd_addr ({fbank_ff, fidx_ff}),
      .rd_data (rd_data)
   );

   assign status.echo       = echo_ff;
   assign status.act_now    = act_now;
   assign status.act        = act_ff;
   assign status.slot_free  = !rsp_valid_ff || rsp_ready;
   assign status.final_char = final_char;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

`default_nettype wire

>>> rtl/atclc_controller.sv
`default_nettype none

module atclc_controller
   import atclc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire status_type status,
   output logic            req_ready,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (status.echo) begin
                  state_in = ST_ECHO;
               end else begin
                  case (status.act_now)
                     ACT_LINE:  state_in = ST_READ;
                     ACT_EMPTY: state_in = ST_EMPTY;
                     default:   state_in = ST_IDLE;
                  endcase
               end
            end
         end
         ST_ECHO: begin
            if (status.slot_free) begin
               case (status.act)
                  ACT_LINE:  state_in = ST_READ;
                  ACT_EMPTY: state_in = ST_EMPTY;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_CHAR;
         end
         ST_CHAR: begin
            if (status.slot_free) begin
               state_in = status.final_char ? ST_IDLE : ST_READ;
            end
         end
         ST_EMPTY: begin
            if (status.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready      = (state_ff == ST_IDLE);
      cmd.accept     = (state_ff == ST_IDLE) && req_valid;
      cmd.load_echo  = (state_ff == ST_ECHO) && status.slot_free;
      cmd.issue_read = (state_ff == ST_READ);
      cmd.load_char  = (state_ff == ST_CHAR) && status.slot_free;
      cmd.load_empty = (state_ff == ST_EMPTY) && status.slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/at_command_line_capture_unit.sv
// Echo path: an accepted byte is registered, then moved into the output register in the echo state
// once the output slot is free. Flow: one byte at a time; a byte causing no line output frees the
// input once the controller is back in idle, a completed line is sent character by character
// (registered line-store read, then output load, per character), stalled while rsp_ready is low.
// Reset (synchronous): control registers return to 13/10/8/echo on, hunt and lengths clear;
// the line store is not cleared.
`default_nettype none

module at_command_line_capture_unit
   import atclc_pkg::*;
#(
   parameter int LINE_SIZE = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_we,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_byte_in,
   input  wire logic       req_chunk_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [1:0]      rsp_kind,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_last
);

   cmd_type    cmd;
   status_type status;
   logic       unused_chunk_last;

   // chunk boundaries carry no meaning for parsing
   assign unused_chunk_last = req_chunk_last;

   atclc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   atclc_datapath #(
      .LINE_SIZE (LINE_SIZE)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_byte_in  (req_byte_in),
      .rsp_ready    (rsp_ready),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_kind     (rsp_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.load_echo, cmd.issue_read, cmd.load_char, cmd.load_empty}))
      else $error("more than one controller command in a cycle");

   a_char_needs_line: assert property (@(posedge clock) disable iff (reset)
      cmd.load_char |-> (status.act == ACT_LINE))
      else $error("line character loaded without a line to flush");

   a_empty_needs_marker: assert property (@(posedge clock) disable iff (reset)
      cmd.load_empty |-> (status.act == ACT_EMPTY))
      else $error("empty-line marker loaded for a non-empty line");

   a_no_accept_during_read: assert property (@(posedge clock) disable iff (reset)
      cmd.issue_read |=> !req_ready)
      else $error("new transaction taken while a line character is in flight");

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import atclc_pkg::*;

   localparam int LINE_SIZE  = 32;
   localparam int IW         = $clog2(LINE_SIZE);
   localparam int IDLE_SLACK = 8;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic       last;
   } line_result_type;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       csr_we         = 1'b0;
   logic [1:0] csr_index      = CSR_TERMINATOR;
   logic [7:0] csr_wdata      = 8'h00;
   logic       req_valid      = 1'b0;
   logic [7:0] req_byte_in    = 8'h00;
   logic       req_chunk_last = 1'b0;
   logic       rsp_ready      = 1'b0;
   logic       req_ready;
   logic       rsp_valid;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;

   // predictor copy of the control registers and capture state
   logic [7:0] term_reg, lf_reg, bs_reg;
   logic       echo_on;
   logic       hunt_a, capturing;
   int         line_len, saved_len;
   logic [6:0] line_store [LINE_SIZE];
   logic [6:0] saved_store [LINE_SIZE];

   line_result_type predicted_outputs [$];
   int mismatches  = 0;
   int bytes_sent  = 0;
   int hold_cycles = 0;
   int ready_gap   = 0;
   bit no_idle     = 1'b0;

   at_command_line_capture_unit #(.LINE_SIZE(LINE_SIZE)) dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_byte_in(req_byte_in),
      .req_chunk_last(req_chunk_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last(rsp_last)
   );

   always #2 clock = ~clock;

   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 40) $display("%0t ns: %s", $time, what);
   endtask

   // emit the captured line, save it for replay, go back to hunting
   task automatic flush_line(ref line_result_type batch [$]);
      if (line_len == 0) begin
         batch.push_back(line_result_type'{KIND_EMPTY, 8'h00, 1'b0});
      end else begin
         for (int i = 0; i < line_len; i++)
            batch.push_back(line_result_type'{KIND_CHAR, {1'b0, line_store[IW'(i)]}, 1'b0});
      end
      saved_store = line_store;
      saved_len   = line_len;
      line_len    = 0;
      hunt_a      = 1'b0;
      capturing   = 1'b0;
   endtask

   task automatic model_capture_byte(input logic [7:0] ch);
      line_result_type batch [$];
      logic [6:0]      bare;
      logic            is_a, is_t;
      bare = ch[6:0];
      is_a = (bare == CH_UPPER_A) || (bare == CH_LOWER_A);
      is_t = (bare == CH_UPPER_T) || (bare == CH_LOWER_T);
      if (echo_on) batch.push_back(line_result_type'{KIND_ECHO, ch, 1'b0});
      if (!capturing) begin
         if (!hunt_a) begin
            if (is_a) hunt_a = 1'b1;
         end else if (is_t) begin
            capturing = 1'b1;
            line_len  = 0;
         end else if (bare == CH_SLASH) begin
            line_store = saved_store;
            line_len   = saved_len;
            flush_line(batch);
         end else if (!is_a) begin
            hunt_a = 1'b0;
         end
      end else if ({1'b0, bare} == bs_reg) begin
         if (line_len > 0) line_len--;
      end else if ({1'b0, bare} == term_reg) begin
         flush_line(batch);
      end else if ({1'b0, bare} == lf_reg) begin
         // line feed inside a command: drop
      end else if (line_len + 1 < LINE_SIZE) begin
         line_store[IW'(line_len)] = bare;
         line_len++;
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) predicted_outputs.push_back(batch[i]);
   endtask

   // track register writes and accepted bytes, then check each result transaction
   always @(posedge clock) begin
      line_result_type due;
      if (reset) begin
         term_reg  = RESET_TERMINATOR;
         lf_reg    = RESET_LINEFEED;
         bs_reg    = RESET_BACKSPACE;
         echo_on   = 1'b1;
         hunt_a    = 1'b0;
         capturing = 1'b0;
         line_len  = 0;
         saved_len = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TERMINATOR: term_reg = csr_wdata;
               CSR_LINEFEED:   lf_reg   = csr_wdata;
               CSR_BACKSPACE:  bs_reg   = csr_wdata;
               CSR_ECHO:       echo_on  = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) model_capture_byte(req_byte_in);
         if (rsp_valid && rsp_ready) begin
            if (predicted_outputs.size() == 0) begin
               report_mismatch($sformatf("unexpected result kind %0d byte %02h last %0b",
                                         rsp_kind, rsp_out_byte, rsp_last));
            end else begin
               due = predicted_outputs.pop_front();
               if (rsp_kind !== due.kind)
                  report_mismatch($sformatf("kind %0d, expected %0d", rsp_kind, due.kind));
               if (rsp_out_byte !== due.out_byte)
                  report_mismatch($sformatf("out_byte %02h, expected %02h",
                                            rsp_out_byte, due.out_byte));
               if (rsp_last !== due.last)
                  report_mismatch($sformatf("last %0b, expected %0b", rsp_last, due.last));
            end
         end
      end
   end

   // result side: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles--;
      end else if (ready_gap > 0) begin
         rsp_ready <= 1'b0;
         ready_gap--;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 2) == 0) ready_gap = pick_gap();
      end
   end

   task automatic send_byte(input logic [7:0] ch);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_byte_in    <= ch;
      req_chunk_last <= 1'($urandom_range(0, 1));
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      foreach (s[i]) send_byte(s[i]);
   endtask

   // write all four registers in consecutive cycles, holding the write enable
   task automatic program_controls(input logic [7:0] term, input logic [7:0] lf,
                                   input logic [7:0] bs, input logic echo);
      csr_we    <= 1'b1;
      csr_index <= CSR_TERMINATOR;
      csr_wdata <= term;
      @(posedge clock);
      csr_index <= CSR_LINEFEED;
      csr_wdata <= lf;
      @(posedge clock);
      csr_index <= CSR_BACKSPACE;
      csr_wdata <= bs;
      @(posedge clock);
      csr_index <= CSR_ECHO;
      csr_wdata <= {7'd0, echo};
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (predicted_outputs.size() != 0);
      // a captured byte gives no result; let the block settle before any write
      repeat (IDLE_SLACK) @(posedge clock);
   endtask

   function automatic logic [7:0] any_case(input logic [6:0] upper);
      logic [6:0] ch;
      logic       top;
      ch  = $urandom_range(0, 1) ? upper : (upper | 7'h20);
      top = ($urandom_range(0, 4) == 0);
      return {top, ch};
   endfunction

   task automatic test_directed_capture();
      logic [7:0] script [0:23];
      script = '{8'hFF, 8'hC1, "a", 8'hF4, RESET_BACKSPACE, 8'h00, 8'hFF, "x",
                 RESET_LINEFEED, RESET_BACKSPACE, 8'h8A, RESET_TERMINATOR,
                 "A", "/", "a", "T", RESET_TERMINATOR,
                 "A", "q", "T", "a", "t", "Z", 8'h8D};
      foreach (script[i]) send_byte(script[i]);
      wait_idle();
   endtask

   task automatic test_control_registers();
      // terminator 0 is matched by 0x80 once the top bit is stripped
      program_controls(8'h00, 8'h7F, 8'h20, 1'b0);
      send_text("AThi ");
      send_byte(8'hFF);
      send_byte(8'h80);
      send_text("a/");
      wait_idle();
      // codes above 127 never match: overrun the buffer, then close it normally
      program_controls(8'hFF, 8'h00, 8'h80, 1'b1);
      send_text("At");
      repeat (36) send_byte(8'($urandom_range(1, 255)));
      send_byte(8'hFF);
      send_byte(8'h80);
      wait_idle();
      program_controls(RESET_TERMINATOR, RESET_LINEFEED, RESET_BACKSPACE, 1'b1);
      send_byte(RESET_TERMINATOR);
      wait_idle();
      // backspace wins over terminator, terminator over line feed
      program_controls(RESET_TERMINATOR, RESET_TERMINATOR, RESET_TERMINATOR, 1'b0);
      send_text("ATxy");
      send_byte(RESET_TERMINATOR);
      wait_idle();
      program_controls(RESET_TERMINATOR, RESET_TERMINATOR, RESET_BACKSPACE, 1'b1);
      send_byte(RESET_TERMINATOR);
      wait_idle();
      program_controls(8'h7F, 8'hFF, 8'h00, 1'b1);
      send_text("AT");
      send_byte(8'h00);
      send_text("k");
      send_byte(8'h80);
      send_text("m");
      send_byte(8'h8A);
      send_byte(8'hFF);
      wait_idle();
   endtask

   task automatic test_output_backpressure();
      program_controls(RESET_TERMINATOR, RESET_LINEFEED, RESET_BACKSPACE, 1'b1);
      hold_cycles = 400;
      no_idle     = 1'b1;
      send_text("AT+GMI=1234567");
      send_byte(RESET_TERMINATOR);
      send_text("a/");
      no_idle = 1'b0;
      // hold the sender until every result has drained
      wait_idle();
      send_text("at&f");
      send_byte(RESET_TERMINATOR);
      wait_idle();
   endtask

   task automatic send_random_sequence();
      int         r, len;
      logic [7:0] ch;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else if (r < 22) begin
         send_byte(any_case(CH_UPPER_A));
         send_byte({1'b0, CH_SLASH} | ($urandom_range(0, 3) == 0 ? 8'h80 : 8'h00));
      end else begin
         repeat ($urandom_range(1, 2)) send_byte(any_case(CH_UPPER_A));
         send_byte(any_case(CH_UPPER_T));
         r   = $urandom_range(0, 99);
         len = (r < 85) ? $urandom_range(0, 8) :
               (r < 95) ? $urandom_range(9, 30) : $urandom_range(31, 40);
         repeat (len) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
               send_byte(bs_reg);
            end else if (r < 12) begin
               send_byte(lf_reg);
            end else begin
               ch = 8'($urandom_range(0, 255));
               if ({1'b0, ch[6:0]} == term_reg) ch = ch ^ 8'h01;
               send_byte(ch);
            end
         end
         // leave a few lines open so that the next command runs into them
         if ($urandom_range(0, 9) != 0)
            send_byte(term_reg | ($urandom_range(0, 1) ? 8'h80 : 8'h00));
      end
   endtask

   task automatic test_random_lines();
      int         phase_start;
      logic [7:0] term, lf, bs;
      logic       echo;
      for (int p = 0; p < 6; p++) begin
         term = $urandom_range(0, 1) ? RESET_TERMINATOR : 8'($urandom_range(0, 127));
         lf   = $urandom_range(0, 1) ? RESET_LINEFEED : 8'($urandom_range(0, 255));
         bs   = $urandom_range(0, 1) ? RESET_BACKSPACE : 8'($urandom_range(0, 255));
         echo = 1'($urandom_range(0, 1));
         program_controls(term, lf, bs, echo);
         no_idle     = (p == 3);
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < 38) send_random_sequence();
         wait_idle();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed_capture();
      test_control_registers();
      test_output_backpressure();
      test_random_lines();
      wait_idle();
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
